// ----- src/bacr_pkg.sv -----
// Package with shared types, constants and scaling functions for the control ramp block.
`timescale 1ns / 1ps
`default_nettype none

package bacr_pkg;

    localparam int STEER_MIN_DEF    = 72;
    localparam int STEER_MAX_DEF    = 184;
    localparam int STEER_CENTRE_DEF = 128;
    localparam int PEDAL_LOW_DEF    = 48;
    localparam int PEDAL_HIGH_DEF   = 144;

    localparam logic [1:0] CFG_STEER_STEP = 2'd0;
    localparam logic [1:0] CFG_PEDAL_RATE = 2'd1;
    localparam logic [1:0] CFG_FIX_MODE   = 2'd2;

    localparam logic [3:0] STEER_STEP_RST = 4'd3;
    localparam logic [3:0] PEDAL_RATE_RST = 4'd4;

    localparam logic signed [9:0] SCALE_CENTRE = 10'sh080;
    localparam logic [7:0]        PEDAL_ZERO   = 8'h30;
    localparam logic [15:0]       STEER_RECIP  = 16'd37450;
    localparam logic [15:0]       PEDAL_RECIP  = 16'd43241;
    localparam logic [9:0]        STEER_LIMIT  = 10'h07F;
    localparam logic [9:0]        PEDAL_LIMIT  = 10'h0FF;

    typedef struct packed {
        logic left_held;
        logic right_held;
        logic accel_held;
        logic brake_held;
        logic crash_hold;
        logic crash_running;
    } item_t;

    // Steering scale is (pos - 0x80) * 0x100 / 0x70, truncated toward zero and saturated to +-0x7F.
    // The magnitude times 16/7 is formed with a reciprocal that is exact for every 8-bit magnitude.
    function automatic logic [7:0] scale_steer(input logic [7:0] pos);
        logic signed [9:0] diff;
        logic [7:0]        mag;
        logic [23:0]       prod;
        logic [9:0]        quo;
        logic [7:0]        lim;
        diff = $signed({2'b00, pos}) - SCALE_CENTRE;
        mag  = diff[9] ? 8'(-diff) : diff[7:0];
        prod = mag * STEER_RECIP;
        quo  = prod[23:14];
        lim  = (quo > STEER_LIMIT) ? STEER_LIMIT[7:0] : quo[7:0];
        return diff[9] ? 8'(-lim) : lim;
    endfunction

    // Pedal scale is (clamp(p) - 0x30) * 0x100 / 0x61, saturated to 0..0xFF.
    function automatic logic [7:0] scale_pedal(input logic [7:0] pos,
                                               input logic [7:0] low,
                                               input logic [7:0] high);
        logic [7:0]  p;
        logic [7:0]  mag;
        logic [23:0] prod;
        logic [9:0]  quo;
        p    = (pos > high) ? high : ((pos < low) ? low : pos);
        mag  = (p > PEDAL_ZERO) ? (p - PEDAL_ZERO) : 8'd0;
        prod = mag * PEDAL_RECIP;
        quo  = prod[23:14];
        return (quo > PEDAL_LIMIT) ? PEDAL_LIMIT[7:0] : quo[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/button_to_analog_control_ramp_top.sv -----
// Top level of the button to analog control ramp block.
//
// Each input item carries one frame tick of button and crash flags. The
// block ramps the steering and pedal positions and returns one result item
// per input item with the positions and their scaled control values.
// The input and output channels use valid and stall; an item moves on a
// rising edge where valid is high and stall is low.
// The configuration channel writes the steering step, the pedal rate and
// the fix mode by index; the user must write only while the block is idle,
// which it does not enforce. It is always ready; other indexes are ignored.
// A result item passes from the input register to the result register and
// is valid once it is loaded there. The ramp, scaling and accumulator
// logic sits between the input register and the result register, so one
// item is accepted in every cycle while the receiver does not stall.
// Reset centres the steering, zeroes both pedals and the steering value, and
// loads the default register values.
// When the receiver stalls, the result holds, the input register keeps one
// more item, and then in_stall rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module button_to_analog_control_ramp_top #(
    parameter int STEER_MIN    = bacr_pkg::STEER_MIN_DEF,
    parameter int STEER_MAX    = bacr_pkg::STEER_MAX_DEF,
    parameter int STEER_CENTRE = bacr_pkg::STEER_CENTRE_DEF,
    parameter int PEDAL_LOW    = bacr_pkg::PEDAL_LOW_DEF,
    parameter int PEDAL_HIGH   = bacr_pkg::PEDAL_HIGH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        left_held,
    input  wire logic        right_held,
    input  wire logic        accel_held,
    input  wire logic        brake_held,
    input  wire logic        crash_hold,
    input  wire logic        crash_running,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       steer_position,
    output logic [7:0]       accel_position,
    output logic [7:0]       brake_position,
    output logic signed [7:0] steer_value,
    output logic [7:0]       accel_value,
    output logic [7:0]       brake_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    logic [3:0]      steer_step_reg;
    logic [3:0]      pedal_rate_reg;
    logic            fix_mode_reg;
    logic            s1_valid_reg;
    bacr_pkg::item_t s1_item_reg;
    logic            out_valid_reg;
    logic [7:0]      steer_position_reg;
    logic [7:0]      accel_position_reg;
    logic [7:0]      brake_position_reg;
    logic [7:0]      steer_value_reg;
    logic [7:0]      accel_value_reg;
    logic [7:0]      brake_value_reg;
    logic            out_free;
    logic            s1_adv;
    logic            in_take;
    logic [7:0]      steer_pos_next;
    logic [7:0]      steer_scaled_next;
    logic [7:0]      accel_pos_next;
    logic [7:0]      accel_val_next;
    logic [7:0]      brake_pos_next;
    logic [7:0]      brake_val_next;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_step_reg <= bacr_pkg::STEER_STEP_RST;
            pedal_rate_reg <= bacr_pkg::PEDAL_RATE_RST;
            fix_mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bacr_pkg::CFG_STEER_STEP: steer_step_reg <= cfg_data;
                bacr_pkg::CFG_PEDAL_RATE: pedal_rate_reg <= cfg_data;
                bacr_pkg::CFG_FIX_MODE:   fix_mode_reg   <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= '{left_held, right_held, accel_held, brake_held,
                             crash_hold, crash_running};
        end
        if (s1_adv)
        begin
            steer_position_reg <= steer_pos_next;
            accel_position_reg <= accel_pos_next;
            brake_position_reg <= brake_pos_next;
            steer_value_reg    <= steer_scaled_next;
            accel_value_reg    <= accel_val_next;
            brake_value_reg    <= brake_val_next;
        end
    end

    bacr_steer #(
        .STEER_MIN    (STEER_MIN),
        .STEER_MAX    (STEER_MAX),
        .STEER_CENTRE (STEER_CENTRE)
    ) u_steer (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .item        (s1_item_reg),
        .step        (steer_step_reg),
        .fix_mode    (fix_mode_reg),
        .pos_next    (steer_pos_next),
        .scaled_next (steer_scaled_next)
    );

    bacr_pedal #(
        .PEDAL_LOW  (PEDAL_LOW),
        .PEDAL_HIGH (PEDAL_HIGH)
    ) u_accel (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (s1_adv),
        .held       (s1_item_reg.accel_held),
        .speed      (pedal_rate_reg),
        .pos_next   (accel_pos_next),
        .value_next (accel_val_next)
    );

    bacr_pedal #(
        .PEDAL_LOW  (PEDAL_LOW),
        .PEDAL_HIGH (PEDAL_HIGH)
    ) u_brake (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (s1_adv),
        .held       (s1_item_reg.brake_held),
        .speed      (pedal_rate_reg),
        .pos_next   (brake_pos_next),
        .value_next (brake_val_next)
    );

    assign out_valid      = out_valid_reg;
    assign steer_position = steer_position_reg;
    assign accel_position = accel_position_reg;
    assign brake_position = brake_position_reg;
    assign steer_value    = $signed(steer_value_reg);
    assign accel_value    = accel_value_reg;
    assign brake_value    = brake_value_reg;

endmodule

`default_nettype wire

// ----- src/bacr_pedal.sv -----
// Pedal position ramp with saturation and scaled pedal value.
`timescale 1ns / 1ps
`default_nettype none

module bacr_pedal #(
    parameter int PEDAL_LOW  = bacr_pkg::PEDAL_LOW_DEF,
    parameter int PEDAL_HIGH = bacr_pkg::PEDAL_HIGH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       held,
    input  wire logic [3:0] speed,
    output logic [7:0]      pos_next,
    output logic [7:0]      value_next
);

    localparam logic [7:0] LOW8  = 8'(PEDAL_LOW);
    localparam logic [7:0] HIGH8 = 8'(PEDAL_HIGH);

    logic [7:0]        pos_reg;
    logic signed [9:0] inc;
    logic signed [9:0] sum;

    assign inc = $signed({4'b0000, speed, 2'b00});

    always_comb
    begin
        if (held)
        begin
            sum = $signed({2'b00, pos_reg}) + inc;
            pos_next = (sum > 10'sd255) ? 8'hFF : sum[7:0];
        end
        else
        begin
            sum = $signed({2'b00, pos_reg}) - inc;
            pos_next = sum[9] ? 8'h00 : sum[7:0];
        end
        value_next = bacr_pkg::scale_pedal(pos_next, LOW8, HIGH8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'h00;
        end
        else if (adv)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bacr_steer.sv -----
// Steering position ramp, change accumulator and held steering value.
`timescale 1ns / 1ps
`default_nettype none

module bacr_steer #(
    parameter int STEER_MIN    = bacr_pkg::STEER_MIN_DEF,
    parameter int STEER_MAX    = bacr_pkg::STEER_MAX_DEF,
    parameter int STEER_CENTRE = bacr_pkg::STEER_CENTRE_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire bacr_pkg::item_t item,
    input  wire logic [3:0]     step,
    input  wire logic           fix_mode,
    output logic [7:0]          pos_next,
    output logic [7:0]          scaled_next
);

    localparam logic signed [9:0] MIN10    = 10'(STEER_MIN);
    localparam logic signed [9:0] MAX10    = 10'(STEER_MAX);
    localparam logic signed [9:0] CENTRE10 = 10'(STEER_CENTRE);
    localparam logic [7:0]        CENTRE8  = 8'(STEER_CENTRE);

    logic [7:0]        pos_reg;
    logic [7:0]        prev_reg;
    logic [9:0]        sum_reg;
    logic [7:0]        scaled_reg;
    logic [7:0]        prev_next;
    logic [9:0]        sum_next;
    logic signed [9:0] p;
    logic signed [9:0] st;
    logic [9:0]        delta;
    logic [9:0]        sum_add;
    logic              big;
    logic [7:0]        scaled_new;

    assign st = $signed({6'b000000, step});

    always_comb
    begin
        p = $signed({2'b00, pos_reg});
        if (item.left_held)
        begin
            if (p > CENTRE10)
            begin
                p = CENTRE10;
            end
            p = p - st;
            if (p < MIN10)
            begin
                p = MIN10;
            end
        end
        else if (item.right_held)
        begin
            if (p < CENTRE10)
            begin
                p = CENTRE10;
            end
            p = p + st;
            if (p > MAX10)
            begin
                p = MAX10;
            end
        end
        else if (p < CENTRE10)
        begin
            p = p + st;
            if (p > CENTRE10)
            begin
                p = CENTRE10;
            end
        end
        else if (p > CENTRE10)
        begin
            p = p - st;
            if (p < CENTRE10)
            begin
                p = CENTRE10;
            end
        end
        if (p < MIN10)
        begin
            p = MIN10;
        end
        else if (p > MAX10)
        begin
            p = MAX10;
        end
        pos_next = p[7:0];
    end

    assign delta      = {2'b00, pos_next} - {2'b00, prev_reg};
    assign sum_add    = sum_reg + delta;
    assign big        = ($signed(sum_add) > 10'sd2) || ($signed(sum_add) < -10'sd2);
    assign scaled_new = item.crash_running ? 8'h00 : bacr_pkg::scale_steer(pos_next);

    always_comb
    begin
        prev_next   = prev_reg;
        sum_next    = sum_reg;
        scaled_next = scaled_reg;
        if (item.crash_hold)
        begin
            scaled_next = scaled_new;
        end
        else
        begin
            prev_next = pos_next;
            if (fix_mode || big)
            begin
                sum_next    = 10'd0;
                scaled_next = scaled_new;
            end
            else
            begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= CENTRE8;
            prev_reg   <= CENTRE8;
            sum_reg    <= 10'd0;
            scaled_reg <= 8'h00;
        end
        else if (adv)
        begin
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            sum_reg    <= sum_next;
            scaled_reg <= scaled_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the button to analog control ramp block.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam logic [1:0] CFG_UNUSED      = 2'd3;
    localparam int         SCALE_MID       = 'h80;
    localparam int         SCALE_SPAN      = 'h100;
    localparam int         STEER_DIV       = 'h70;
    localparam int         STEER_LIM       = 'h7F;
    localparam int         PEDAL_OFFSET    = 'h30;
    localparam int         PEDAL_DIV       = 'h61;
    localparam int         PEDAL_FULL      = 'hFF;
    localparam int         PEDAL_STEP_MULT = 4;
    localparam int         DELTA_THRESHOLD = 2;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         HOLD_OFF_CYCLES = 60;
    localparam int         RUN_ITEMS       = 65;

    typedef struct packed {
        logic [7:0]        steer_position;
        logic [7:0]        accel_position;
        logic [7:0]        brake_position;
        logic signed [7:0] steer_value;
        logic [7:0]        accel_value;
        logic [7:0]        brake_value;
    } controls_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic left_held;
    logic right_held;
    logic accel_held;
    logic brake_held;
    logic crash_hold;
    logic crash_running;
    logic out_valid;
    logic out_stall;
    logic [7:0] steer_position;
    logic [7:0] accel_position;
    logic [7:0] brake_position;
    logic signed [7:0] steer_value;
    logic [7:0] accel_value;
    logic [7:0] brake_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    logic [3:0]        steer_step_reg;
    logic [3:0]        pedal_rate_reg;
    logic              fix_mode_reg;
    logic [7:0]        steer_pos_q;
    logic [7:0]        accel_pos_q;
    logic [7:0]        brake_pos_q;
    logic [7:0]        steer_prev_q;
    logic signed [9:0] delta_sum_q;
    logic signed [7:0] steer_value_q;

    controls_t pending_controls[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_request;
    int ticks_sent;
    int results_checked;
    int reg_writes;
    int mismatches;

    button_to_analog_control_ramp_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_held      (left_held),
        .right_held     (right_held),
        .accel_held     (accel_held),
        .brake_held     (brake_held),
        .crash_hold     (crash_hold),
        .crash_running  (crash_running),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .steer_position (steer_position),
        .accel_position (accel_position),
        .brake_position (brake_position),
        .steer_value    (steer_value),
        .accel_value    (accel_value),
        .brake_value    (brake_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int steer_to_value(int pos);
        int d;
        d = ((pos - SCALE_MID) * SCALE_SPAN) / STEER_DIV;
        if (d > STEER_LIM)
            d = STEER_LIM;
        else if (d < -STEER_LIM)
            d = -STEER_LIM;
        return d;
    endfunction

    function automatic int pedal_to_value(int p);
        int v;
        if (p > bacr_pkg::PEDAL_HIGH_DEF)
            p = bacr_pkg::PEDAL_HIGH_DEF;
        else if (p < bacr_pkg::PEDAL_LOW_DEF)
            p = bacr_pkg::PEDAL_LOW_DEF;
        v = ((p - PEDAL_OFFSET) * SCALE_SPAN) / PEDAL_DIV;
        if (v < 0)
            v = 0;
        else if (v > PEDAL_FULL)
            v = PEDAL_FULL;
        return v;
    endfunction

    function automatic logic [7:0] ramp_pedal(logic [7:0] p, logic held, int inc);
        int v;
        v = held ? int'(p) + inc : int'(p) - inc;
        if (v > PEDAL_FULL)
            v = PEDAL_FULL;
        else if (v < 0)
            v = 0;
        return 8'(v);
    endfunction

    function automatic controls_t advance_controls(bacr_pkg::item_t it);
        controls_t r;
        int        pos;
        int        step;
        int        diff;
        int        mag;
        pos  = steer_pos_q;
        step = steer_step_reg;
        if (it.left_held)
        begin
            if (pos > bacr_pkg::STEER_CENTRE_DEF)
                pos = bacr_pkg::STEER_CENTRE_DEF;
            pos -= step;
            if (pos < bacr_pkg::STEER_MIN_DEF)
                pos = bacr_pkg::STEER_MIN_DEF;
        end
        else if (it.right_held)
        begin
            if (pos < bacr_pkg::STEER_CENTRE_DEF)
                pos = bacr_pkg::STEER_CENTRE_DEF;
            pos += step;
            if (pos > bacr_pkg::STEER_MAX_DEF)
                pos = bacr_pkg::STEER_MAX_DEF;
        end
        else if (pos < bacr_pkg::STEER_CENTRE_DEF)
        begin
            pos += step;
            if (pos > bacr_pkg::STEER_CENTRE_DEF)
                pos = bacr_pkg::STEER_CENTRE_DEF;
        end
        else if (pos > bacr_pkg::STEER_CENTRE_DEF)
        begin
            pos -= step;
            if (pos < bacr_pkg::STEER_CENTRE_DEF)
                pos = bacr_pkg::STEER_CENTRE_DEF;
        end
        if (pos < bacr_pkg::STEER_MIN_DEF)
            pos = bacr_pkg::STEER_MIN_DEF;
        else if (pos > bacr_pkg::STEER_MAX_DEF)
            pos = bacr_pkg::STEER_MAX_DEF;
        steer_pos_q = 8'(pos);

        accel_pos_q = ramp_pedal(accel_pos_q, it.accel_held,
                                 PEDAL_STEP_MULT * int'(pedal_rate_reg));
        brake_pos_q = ramp_pedal(brake_pos_q, it.brake_held,
                                 PEDAL_STEP_MULT * int'(pedal_rate_reg));

        if (it.crash_hold)
        begin
            steer_value_q = it.crash_running ? 8'sd0 : 8'(steer_to_value(pos));
        end
        else
        begin
            diff         = pos - int'(steer_prev_q);
            steer_prev_q = 8'(pos);
            delta_sum_q  = 10'(int'(delta_sum_q) + diff);
            mag          = (delta_sum_q < 0) ? -int'(delta_sum_q) : int'(delta_sum_q);
            if (fix_mode_reg || mag > DELTA_THRESHOLD)
            begin
                delta_sum_q   = '0;
                steer_value_q = it.crash_running ? 8'sd0 : 8'(steer_to_value(pos));
            end
        end

        r.steer_position = steer_pos_q;
        r.accel_position = accel_pos_q;
        r.brake_position = brake_pos_q;
        r.steer_value    = steer_value_q;
        r.accel_value    = 8'(pedal_to_value(accel_pos_q));
        r.brake_value    = 8'(pedal_to_value(brake_pos_q));
        return r;
    endfunction

    function automatic bacr_pkg::item_t tick_of(bit l, bit r, bit a, bit b, bit h, bit c);
        bacr_pkg::item_t it;
        it.left_held     = l;
        it.right_held    = r;
        it.accel_held    = a;
        it.brake_held    = b;
        it.crash_hold    = h;
        it.crash_running = c;
        return it;
    endfunction

    function automatic logic [3:0] pick_setting();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 4'd15 : 4'd1;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at result %0d: %s", results_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] expected, logic [7:0] got);
        if (got !== expected)
            report_mismatch($sformatf("%s expected 0x%02h, got 0x%02h", name, expected, got));
    endtask

    task automatic send_tick(bacr_pkg::item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_held     <= it.left_held;
        right_held    <= it.right_held;
        accel_held    <= it.accel_held;
        brake_held    <= it.brake_held;
        crash_hold    <= it.crash_hold;
        crash_running <= it.crash_running;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_controls = {pending_controls, advance_controls(it)};
        ticks_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_controls.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            bacr_pkg::CFG_STEER_STEP: steer_step_reg = value;
            bacr_pkg::CFG_PEDAL_RATE: pedal_rate_reg = value;
            bacr_pkg::CFG_FIX_MODE:   fix_mode_reg   = value[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        controls_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_controls.size() == 0)
            begin
                report_mismatch("result arrived with none expected");
            end
            else
            begin
                want = pending_controls.pop_front();
                check_field("steer_position", want.steer_position, steer_position);
                check_field("accel_position", want.accel_position, accel_position);
                check_field("brake_position", want.brake_position, brake_position);
                check_field("steer_value", want.steer_value, steer_value);
                check_field("accel_value", want.accel_value, accel_value);
                check_field("brake_value", want.brake_value, brake_value);
            end
            results_checked++;
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_left        = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic test_default_ramp();
        send_tick(tick_of(0, 0, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, 0, 0, 0));
        send_tick(tick_of(0, 1, 0, 0, 0, 0));
        send_tick(tick_of(1, 1, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 1, 1, 0, 0));
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(bacr_pkg::CFG_STEER_STEP, 4'd15);
        write_reg(bacr_pkg::CFG_PEDAL_RATE, 4'd15);
        repeat (4) send_tick(tick_of(1, 0, 1, 0, 0, 0));
        repeat (4) send_tick(tick_of(0, 1, 0, 1, 0, 0));
        repeat (2) send_tick(tick_of(0, 0, 0, 1, 0, 0));
    endtask

    task automatic test_crash_handling();
        settle();
        write_reg(bacr_pkg::CFG_STEER_STEP, 4'd1);
        send_tick(tick_of(1, 0, 0, 0, 1, 0));
        send_tick(tick_of(1, 0, 0, 0, 1, 1));
        repeat (3) send_tick(tick_of(1, 0, 0, 0, 0, 1));
        send_tick(tick_of(1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_fix_and_zero_steps();
        settle();
        write_reg(bacr_pkg::CFG_FIX_MODE, 4'd1);
        repeat (2) send_tick(tick_of(0, 1, 0, 0, 0, 0));
        settle();
        write_reg(bacr_pkg::CFG_STEER_STEP, 4'd0);
        write_reg(bacr_pkg::CFG_PEDAL_RATE, 4'd0);
        send_tick(tick_of(1, 0, 1, 1, 0, 0));
        settle();
        write_reg(CFG_UNUSED, 4'd9);
        send_tick(tick_of(0, 1, 1, 0, 0, 0));
    endtask

    task automatic test_random_driving();
        int              phase;
        int              sent;
        int              run_len;
        int              crash_sel;
        logic [1:0]      steer_sel;
        logic [1:0]      pedal_sel;
        bacr_pkg::item_t it;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
            repeat (4)
            begin
                settle();
                write_reg(bacr_pkg::CFG_STEER_STEP, pick_setting());
                write_reg(bacr_pkg::CFG_PEDAL_RATE, pick_setting());
                write_reg(bacr_pkg::CFG_FIX_MODE, 4'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
                sent = 0;
                while (sent < RUN_ITEMS)
                begin
                    // Buttons are held for runs so the ramps reach their limits.
                    run_len   = $urandom_range(1, 12);
                    steer_sel = 2'($urandom_range(0, 3));
                    pedal_sel = 2'($urandom_range(0, 3));
                    crash_sel = $urandom_range(0, 9);
                    repeat (run_len)
                    begin
                        if (sent < RUN_ITEMS)
                        begin
                            it = tick_of(steer_sel[0], steer_sel[1], pedal_sel[0],
                                         pedal_sel[1], crash_sel < 2,
                                         crash_sel == 1 || crash_sel == 2);
                            if ($urandom_range(0, 9) == 0)
                                it = it ^ bacr_pkg::item_t'(6'b1 << $urandom_range(0, 5));
                            send_tick(it);
                            sent++;
                        end
                    end
                end
            end
        end
    endtask

    task automatic test_output_hold_off();
        settle();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_off_request = 1'b1;
        repeat (30)
            send_tick(bacr_pkg::item_t'(6'($urandom_range(0, 63))));
        settle();
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        left_held        = 1'b0;
        right_held       = 1'b0;
        accel_held       = 1'b0;
        brake_held       = 1'b0;
        crash_hold       = 1'b0;
        crash_running    = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = bacr_pkg::CFG_STEER_STEP;
        cfg_data         = 4'd0;
        hold_off_request = 1'b0;
        send_idle_pct    = 14;
        recv_idle_pct    = 73;
        ticks_sent       = 0;
        results_checked  = 0;
        reg_writes       = 0;
        mismatches       = 0;
        steer_step_reg   = bacr_pkg::STEER_STEP_RST;
        pedal_rate_reg   = bacr_pkg::PEDAL_RATE_RST;
        fix_mode_reg     = 1'b0;
        steer_pos_q      = 8'(bacr_pkg::STEER_CENTRE_DEF);
        accel_pos_q      = 8'd0;
        brake_pos_q      = 8'd0;
        steer_prev_q     = 8'(bacr_pkg::STEER_CENTRE_DEF);
        delta_sum_q      = '0;
        steer_value_q    = 8'sd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_ramp();
        test_register_extremes();
        test_crash_handling();
        test_fix_and_zero_steps();
        test_random_driving();
        test_output_hold_off();

        if (pending_controls.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_controls.size()));
        $display("Drove %0d ticks through %0d register writes and checked %0d results,",
                 ticks_sent, reg_writes, results_checked);
        $display("with random idling on both sides and a %0d cycle output hold-off.",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_controls.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- button_to_analog_control_ramp_top.f -----
src/bacr_pkg.sv
src/bacr_pedal.sv
src/bacr_steer.sv
src/button_to_analog_control_ramp_top.sv
tb/testbench.sv
